// ===== design/x86_64_move_add_encoder_assert.svh =====
// Assertion macros for the move and add encoder.
`ifndef X86_64_MOVE_ADD_ENCODER_ASSERT_SVH
`define X86_64_MOVE_ADD_ENCODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define X64ENC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define X64ENC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/x64enc_pkg.sv =====
// Package: statement codes, command/status types and byte tables of the encoder.
package x64enc_pkg;

    localparam int unsigned MODE_W = 3;
    localparam int unsigned REG_W  = 3;
    localparam int unsigned IMM_W  = 64;
    localparam int unsigned POS_W  = 5;

    localparam logic [MODE_W-1:0] MODE_MOV_REG = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MOV_IMM = 3'd1;
    localparam logic [MODE_W-1:0] MODE_EXIT    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ADD_REG = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ADD_IMM = 3'd4;
    localparam logic [MODE_W-1:0] MODE_END     = 3'd5;

    localparam logic [7:0] REX_W      = 8'h48;
    localparam logic [7:0] OP_MOV_RR  = 8'h89;
    localparam logic [7:0] OP_MOV_IMM = 8'hB8;
    localparam logic [7:0] OP_ADD_RR  = 8'h01;
    localparam logic [7:0] OP_ADD_IMM = 8'h81;
    localparam logic [7:0] MODRM_REG  = 8'hC0;
    localparam logic [7:0] SYSCALL_0  = 8'h0F;
    localparam logic [7:0] SYSCALL_1  = 8'h05;
    localparam logic [7:0] NR_EXIT    = 8'd60;
    localparam logic [3:0] X86_RDI    = 4'd7;

    typedef struct packed {
        logic load;
        logic emit;
    } t_enc_cmd;

    typedef struct packed {
        logic mode_ok;
        logic at_last;
    } t_enc_sts;

    // Source register code to x86-64 register number; codes zero and seven both map to rbx.
    function automatic logic [3:0] reg_map(input logic [REG_W-1:0] code);
        logic [3:0] r;
        case (code)
            3'd1:    r = 4'd12;
            3'd2:    r = 4'd13;
            3'd3:    r = 4'd14;
            3'd4:    r = 4'd15;
            3'd5:    r = 4'd4;
            3'd6:    r = 4'd5;
            default: r = 4'd3;
        endcase
        return r;
    endfunction

    function automatic logic [POS_W-1:0] enc_len(input logic [MODE_W-1:0] mode);
        logic [POS_W-1:0] n;
        case (mode)
            MODE_MOV_REG: n = 5'd3;
            MODE_MOV_IMM: n = 5'd10;
            MODE_EXIT:    n = 5'd15;
            MODE_ADD_REG: n = 5'd3;
            MODE_ADD_IMM: n = 5'd7;
            MODE_END:     n = 5'd22;
            default:      n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] imm_byte(input logic [IMM_W-1:0] imm,
                                           input logic [2:0] idx);
        return imm[{idx, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] rex_rr(input logic [3:0] dst, input logic [3:0] src);
        return REX_W | {5'd0, src[3], 1'b0, dst[3]};
    endfunction

    function automatic logic [7:0] modrm_rr(input logic [3:0] dst, input logic [3:0] src);
        return MODRM_REG | {2'b00, src[2:0], dst[2:0]};
    endfunction

    // Byte at position pos of the code for one statement.
    function automatic logic [7:0] enc_byte(input logic [MODE_W-1:0] mode,
                                           input logic [3:0] dst,
                                           input logic [3:0] src,
                                           input logic [IMM_W-1:0] imm,
                                           input logic [POS_W-1:0] pos);
        logic [7:0]       b;
        logic [POS_W-1:0] off2;
        logic [POS_W-1:0] off3;
        b    = 8'h00;
        off2 = pos - 5'd2;
        off3 = pos - 5'd3;
        case (mode)
            MODE_MOV_REG, MODE_ADD_REG: begin
                if (pos == 5'd0) begin
                    b = rex_rr(dst, src);
                end else if (pos == 5'd1) begin
                    b = (mode == MODE_MOV_REG) ? OP_MOV_RR : OP_ADD_RR;
                end else begin
                    b = modrm_rr(dst, src);
                end
            end
            MODE_MOV_IMM: begin
                if (pos == 5'd0) begin
                    b = REX_W | {7'd0, dst[3]};
                end else if (pos == 5'd1) begin
                    b = OP_MOV_IMM + {5'd0, dst[2:0]};
                end else begin
                    b = imm_byte(imm, off2[2:0]);
                end
            end
            MODE_ADD_IMM: begin
                if (pos == 5'd0) begin
                    b = REX_W | {7'd0, dst[3]};
                end else if (pos == 5'd1) begin
                    b = OP_ADD_IMM;
                end else if (pos == 5'd2) begin
                    b = MODRM_REG | {5'd0, dst[2:0]};
                end else begin
                    b = imm_byte(imm, {1'b0, off3[1:0]});
                end
            end
            MODE_EXIT, MODE_END: begin
                // Both open with mov rax,60 and close with syscall.
                if (pos == 5'd0) begin
                    b = REX_W;
                end else if (pos == 5'd1) begin
                    b = OP_MOV_IMM;
                end else if (pos == 5'd2) begin
                    b = NR_EXIT;
                end else if (pos inside {[5'd3:5'd9]}) begin
                    b = 8'h00;
                end else if (mode == MODE_EXIT) begin
                    case (pos)
                        5'd10:   b = rex_rr(X86_RDI, src);
                        5'd11:   b = OP_MOV_RR;
                        5'd12:   b = modrm_rr(X86_RDI, src);
                        5'd13:   b = SYSCALL_0;
                        default: b = SYSCALL_1;
                    endcase
                end else begin
                    case (pos)
                        5'd10:   b = REX_W;
                        5'd11:   b = OP_MOV_IMM + {5'd0, X86_RDI[2:0]};
                        5'd20:   b = SYSCALL_0;
                        5'd21:   b = SYSCALL_1;
                        default: b = 8'h00;
                    endcase
                end
            end
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== design/x86_64_move_add_encoder.sv =====
// Once start is taken the controller enters its emit state, which registers bytes into o_out_byte one per cycle.
// One statement at a time: start is taken only while idle, and busy stays high until the last byte is emitted.
// A statement with mode six or seven is accepted while idle and emits nothing.
// Reset (i_rst_n low, synchronous) returns to idle with no strobe pending.
// The receiver cannot stall: each byte is strobed by o_valid for exactly one cycle.
// Top level: x86-64 move/add statement encoder.
module x86_64_move_add_encoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [x64enc_pkg::MODE_W-1:0]   i_mode,
    input  logic [x64enc_pkg::REG_W-1:0]    i_dest_register,
    input  logic [x64enc_pkg::REG_W-1:0]    i_source_register,
    input  logic [x64enc_pkg::IMM_W-1:0]    i_immediate,
    output logic                            o_valid,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last_byte
);
    import x64enc_pkg::*;

    `include "x86_64_move_add_encoder_assert.svh"

    t_enc_cmd cmd;
    t_enc_sts sts;

    x64enc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    x64enc_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_mode            (i_mode),
        .i_dest_register   (i_dest_register),
        .i_source_register (i_source_register),
        .i_immediate       (i_immediate),
        .o_out_byte        (o_out_byte),
        .o_last_byte       (o_last_byte)
    );

    `X64ENC_ASSERT_NOW(a_last_has_strobe, i_clk, i_rst_n, o_last_byte, o_valid, "last flag without strobe")
    `X64ENC_ASSERT_NEXT(a_gap_after_last, i_clk, i_rst_n, o_valid && o_last_byte, !o_valid, "byte right after last byte")
    `X64ENC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy && sts.mode_ok, busy && !o_valid, "valid statement did not start")
    `X64ENC_ASSERT_NEXT(a_busy_emits, i_clk, i_rst_n, busy, o_valid, "busy cycle emitted no byte")

endmodule

// ===== design/x64enc_dp.sv =====
// Datapath: statement registers, byte position counter and output byte register.
module x64enc_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  x64enc_pkg::t_enc_cmd            i_cmd,
    output x64enc_pkg::t_enc_sts            o_sts,
    input  logic [x64enc_pkg::MODE_W-1:0]   i_mode,
    input  logic [x64enc_pkg::REG_W-1:0]    i_dest_register,
    input  logic [x64enc_pkg::REG_W-1:0]    i_source_register,
    input  logic [x64enc_pkg::IMM_W-1:0]    i_immediate,
    output logic [7:0]                      o_out_byte,
    output logic                            o_last_byte
);
    import x64enc_pkg::*;

    logic [MODE_W-1:0] r_mode;
    logic [3:0]        r_dst;
    logic [3:0]        r_src;
    logic [IMM_W-1:0]  r_imm;
    logic [POS_W-1:0]  r_pos;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              at_last;

    assign at_last       = (r_pos == enc_len(r_mode) - 5'd1);
    assign o_sts.at_last = at_last;
    assign o_sts.mode_ok = (enc_len(i_mode) != 5'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_out_last <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pos <= '0;
            end else if (i_cmd.emit) begin
                r_pos <= r_pos + 5'd1;
            end
            // Last flag only rides along with a strobed byte.
            r_out_last <= i_cmd.emit && at_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_dst  <= reg_map(i_dest_register);
            r_src  <= reg_map(i_source_register);
            r_imm  <= i_immediate;
        end
        if (i_cmd.emit) begin
            r_out_byte <= enc_byte(r_mode, r_dst, r_src, r_imm, r_pos);
        end
    end

    assign o_out_byte  = r_out_byte;
    assign o_last_byte = r_out_last;

endmodule

// ===== design/x64enc_ctrl.sv =====
// Controller: accepts a statement and sequences one byte emission per cycle.
module x64enc_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    output logic                  o_valid,
    output x64enc_pkg::t_enc_cmd  o_cmd,
    input  x64enc_pkg::t_enc_sts  i_sts
);
    import x64enc_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    assign busy       = (r_state == S_EMIT);
    assign o_cmd.load = start && (r_state == S_IDLE);
    assign o_cmd.emit = (r_state == S_EMIT);

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                // Drop statements with no form: accepted, nothing emitted.
                if (start && i_sts.mode_ok) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                n_valid = 1'b1;
                if (i_sts.at_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_valid = r_valid;

endmodule
